### rtl/qpt_pkg.sv
package qpt_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAPER_END_THRESHOLD = 1'd1;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [2:0] delta_t;

  typedef struct packed {
    logic take_moved;
    logic clear_count;
    logic printing;
    logic pin_b;
    logic pin_a;
  } item_t;

  typedef struct packed {
    logic paper_end_out;
    logic at_edge;
    logic moved;
    pos_t count;
  } result_t;

  typedef struct packed {
    logic [1:0] last_pins;
    pos_t       pos_count;
    pos_t       moved_reference;
    logic       paper_end_level;
  } track_state_t;

  // step per {B, A, B_prev, A_prev}
  localparam delta_t DELTA_TABLE [16] = '{
    3'sd0,  3'sd1, -3'sd1,  3'sd2,
    -3'sd1, 3'sd0, -3'sd2,  3'sd1,
    3'sd1, -3'sd2,  3'sd0, -3'sd1,
    3'sd2, -3'sd1,  3'sd1,  3'sd0
  };

endpackage

### rtl/qpt_step.sv
module qpt_step (
  input  qpt_pkg::track_state_t state,
  input  qpt_pkg::item_t        item,
  input  qpt_pkg::pos_t         edge_threshold,
  input  qpt_pkg::pos_t         paper_end_threshold,
  output qpt_pkg::track_state_t state_nxt,
  output qpt_pkg::result_t      result
);
  import qpt_pkg::*;

  logic [3:0] code;
  delta_t     delta;
  pos_t       stepped;
  pos_t       pos_new;
  logic       differs;

  assign code    = {item.pin_b, item.pin_a, state.last_pins};
  assign delta   = DELTA_TABLE[code];
  assign stepped = state.pos_count + {{(POS_W-3){delta[2]}}, delta};

  always_comb begin
    state_nxt = state;
    if (item.clear_count) begin
      state_nxt.pos_count       = '0;
      state_nxt.moved_reference = '0;
    end else begin
      state_nxt.pos_count = stepped;
      state_nxt.last_pins = {item.pin_b, item.pin_a};
      if (item.printing) begin
        state_nxt.paper_end_level = (paper_end_threshold > stepped);
      end
    end
    pos_new = state_nxt.pos_count;
    differs = item.take_moved && (pos_new != state_nxt.moved_reference);
    if (differs) begin
      state_nxt.moved_reference = pos_new;
    end
    result.count         = pos_new;
    result.moved         = differs;
    result.at_edge       = (pos_new > edge_threshold);
    result.paper_end_out = state_nxt.paper_end_level;
  end

endmodule

### rtl/quadrature_position_tracker.sv
// Quadrature position tracker, x4 decoding of a two-channel encoder.
// Input channel in_*: one item per pin sample with control flags.
// Result channel out_*: exactly one result item per input item, in order.
// Configuration channel cfg_*: index 0 writes edge_threshold, index 1
//   writes paper_end_threshold; always ready, write only while idle.
// Datapath: an accepted item is held in the input register, and its
//   result is then loaded into the result register behind out_tvalid.
// Throughput: one item per cycle while out_tready is high; the decode,
//   32-bit add and two threshold compares sit between the two registers.
// Stall: while out_tready is low the result holds; one more item is
//   taken into the input register, after which in_tready drops.
// Reset (rst_n low, synchronous): both stages empty, position, moved
//   reference, last pin pair and thresholds zero, paper-end level high.
module quadrature_position_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] pin_a, [1] pin_b, [2] printing, [3] clear_count, [4] take_moved
  input  logic [qpt_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] count, [32] moved, [33] at_edge, [34] paper_end_out
  output logic [qpt_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qpt_pkg::POS_W-1:0]           cfg_data
);
  import qpt_pkg::*;

  logic         in_valid_r;
  item_t        in_item_r;
  logic         out_valid_r;
  result_t      out_item_r;
  track_state_t state_r;
  track_state_t state_nxt;
  result_t      result_nxt;
  pos_t         edge_threshold_r;
  pos_t         paper_end_threshold_r;
  logic         advance;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_item_r};

  qpt_step u_step (
    .state               (state_r),
    .item                (in_item_r),
    .edge_threshold      (edge_threshold_r),
    .paper_end_threshold (paper_end_threshold_r),
    .state_nxt           (state_nxt),
    .result              (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.last_pins       <= '0;
      state_r.pos_count       <= '0;
      state_r.moved_reference <= '0;
      state_r.paper_end_level <= 1'b1;
      edge_threshold_r      <= '0;
      paper_end_threshold_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_EDGE_THRESHOLD:      edge_threshold_r      <= cfg_data;
          REG_PAPER_END_THRESHOLD: paper_end_threshold_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_tdata[$bits(item_t)-1:0];
    end
    if (advance) begin
      out_item_r <= result_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_item_r.clear_count |=>
      (out_item_r.count == '0) && !out_item_r.moved)
    else $error("clear item did not zero the position");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_item_r.clear_count |=>
      ((state_r.pos_count - $past(state_r.pos_count)) == 32'sd0 ||
       (state_r.pos_count - $past(state_r.pos_count)) == 32'sd1 ||
       (state_r.pos_count - $past(state_r.pos_count)) == 32'sd2 ||
       (state_r.pos_count - $past(state_r.pos_count)) == -32'sd1 ||
       (state_r.pos_count - $past(state_r.pos_count)) == -32'sd2))
    else $error("position moved by more than two steps");

  a_pe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_item_r.clear_count || !in_item_r.printing) |=>
      $stable(state_r.paper_end_level))
    else $error("paper-end level changed outside printing");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && (out_item_r.count == state_r.pos_count))
    else $error("result count differs from tracked position");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("input stalled with empty input register");
`endif

endmodule

### bench/quadrature_position_tracker_test.sv
module quadrature_position_tracker_test;
  import qpt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // [0] pin_a, [1] pin_b, [2] printing, [3] clear_count, [4] take_moved
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [31:0] count, [32] moved, [33] at_edge, [34] paper_end_out
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [POS_W-1:0] cfg_data = '0;

  quadrature_position_tracker dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t   pending_samples[$];
  result_t expected_results[$];

  logic [1:0] trk_pins = 2'b00;
  pos_t       trk_pos = '0;
  pos_t       trk_mark = '0;
  logic       trk_paper_high = 1'b1;
  pos_t       edge_limit = '0;
  pos_t       paper_limit = '0;

  int send_idle_pct = 19;
  int recv_idle_pct = 54;
  int accepted_items = 0;
  int checked_results = 0;
  int mismatches = 0;

  int hold_left = 0;
  int next_hold_at = 150;

  logic [1:0] walk_phase = 2'd0;
  logic       walk_up = 1'b1;
  logic       print_on = 1'b1;

  task automatic track_sample(input item_t s, output result_t r);
    logic [3:0] code;
    pos_t       step;
    r.moved = 1'b0;
    if (s.clear_count) begin
      trk_pos = '0;
      trk_mark = '0;
    end else begin
      code = {s.pin_b, s.pin_a, trk_pins};
      case (code)
        4'd0, 4'd5, 4'd10, 4'd15: step = 0;
        4'd1, 4'd7, 4'd8, 4'd14:  step = 1;
        4'd2, 4'd4, 4'd11, 4'd13: step = -1;
        4'd3, 4'd12:              step = 2;
        default:                  step = -2;
      endcase
      trk_pos = trk_pos + step;
      trk_pins = {s.pin_b, s.pin_a};
      if (s.printing) trk_paper_high = (trk_pos < paper_limit);
    end
    if (s.take_moved && trk_pos != trk_mark) begin
      trk_mark = trk_pos;
      r.moved = 1'b1;
    end
    r.count = trk_pos;
    r.at_edge = (trk_pos > edge_limit);
    r.paper_end_out = trk_paper_high;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t result %0d %s: got %0h, want %0h", $realtime, checked_results, what,
               got, want);
  endtask

  always @(posedge clk) begin
    result_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_sample(item_t'(in_tdata[$bits(item_t)-1:0]), r);
        expected_results.push_back(r);
        accepted_items++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata <= IN_DATA_W'(pending_samples.pop_front());
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long hold-offs make the block fill and drop in_tready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (accepted_items >= next_hold_at) begin
      hold_left <= 60;
      next_hold_at <= next_hold_at + 700;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, count", got.count, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.count !== want.count) report_mismatch("count", got.count, want.count);
        if (got.moved !== want.moved) report_mismatch("moved", got.moved, want.moved);
        if (got.at_edge !== want.at_edge)
          report_mismatch("at_edge", got.at_edge, want.at_edge);
        if (got.paper_end_out !== want.paper_end_out)
          report_mismatch("paper_end_out", got.paper_end_out, want.paper_end_out);
      end
      checked_results++;
    end
  end

  function automatic item_t mk_sample(input logic [1:0] pins, input logic prt,
                                      input logic clr, input logic qry);
    item_t s;
    s.pin_a = pins[0];
    s.pin_b = pins[1];
    s.printing = prt;
    s.clear_count = clr;
    s.take_moved = qry;
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input pos_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_EDGE_THRESHOLD) edge_limit = val;
    else if (idx == REG_PAPER_END_THRESHOLD) paper_limit = val;
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly legal Gray steps; a few jumps, pauses and clears
  task automatic queue_encoder_walk(input int n);
    item_t s;
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if ($urandom_range(99) < 3) walk_up = !walk_up;
      if ($urandom_range(99) < 8) print_on = !print_on;
      if (roll < 8) walk_phase = 2'($urandom_range(3));
      else if (roll >= 14) walk_phase = walk_up ? walk_phase + 2'd1 : walk_phase - 2'd1;
      s = mk_sample({walk_phase[1], walk_phase[1] ^ walk_phase[0]}, print_on,
                    $urandom_range(99) < 2, $urandom_range(99) < 35);
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    logic [1:0] tour[16];
    pos_t edge_set[6];
    pos_t paper_set[6];
    tour = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
             2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
    edge_set = '{32'sh8000_0000, 32'sh7fff_ffff, 3, -5, 0, 0};
    paper_set = '{32'sh7fff_ffff, 32'sh8000_0000, -4, 6, 0, 0};
    edge_set[4] = $urandom_range(40) - 20;
    paper_set[4] = $urandom_range(40) - 20;

    for (int i = 0; i < 16; i++)
      pending_samples.push_back(mk_sample(tour[i], i % 3 != 0, 1'b0, i % 4 == 1));
    pending_samples.push_back(mk_sample(2'd0, 1'b1, 1'b0, 1'b1));
    pending_samples.push_back(mk_sample(2'd0, 1'b0, 1'b0, 1'b1));
    pending_samples.push_back(mk_sample(2'd1, 1'b1, 1'b1, 1'b1));
    pending_samples.push_back(mk_sample(2'd1, 1'b0, 1'b0, 1'b1));
    pending_samples.push_back(mk_sample(2'd3, 1'b1, 1'b1, 1'b0));
    pending_samples.push_back(mk_sample(2'd3, 1'b1, 1'b1, 1'b1));
    pending_samples.push_back(mk_sample(2'd2, 1'b1, 1'b0, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_EDGE_THRESHOLD, edge_set[ph]);
      write_reg(REG_PAPER_END_THRESHOLD, paper_set[ph]);
      send_idle_pct <= (ph < 2) ? 19 : (ph < 4) ? 54 : 0;
      recv_idle_pct <= (ph < 2) ? 54 : (ph < 4) ? 19 : 0;
      queue_encoder_walk(325);
    end
    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/qpt_pkg.sv
rtl/qpt_step.sv
rtl/quadrature_position_tracker.sv
bench/quadrature_position_tracker_test.sv
